@@ hdl/plist_pkg.sv @@
// Shared constants, operation and status codes, and the control/status
// structs passed between the positional list controller and datapath.
// No dependencies.
package plist_pkg;

   // Store geometry
   localparam int CAPACITY   = 64;
   localparam int DATA_W     = 32;
   localparam int AW         = $clog2(CAPACITY);
   localparam int CW         = $clog2(CAPACITY + 1);

   // Field widths fixed by the interface
   localparam int OP_W       = 3;
   localparam int POS_W      = 6;
   localparam int ST_W       = 2;
   localparam int CNT_PORT_W = 7;

   // Width that holds both a position and a count without wrap
   localparam int CMP_W      = ((CW > POS_W) ? CW : POS_W) + 1;

   // Operation codes
   localparam logic [OP_W-1:0] OP_APPEND      = 3'd0;
   localparam logic [OP_W-1:0] OP_INSERT_AT   = 3'd1;
   localparam logic [OP_W-1:0] OP_REMOVE_LAST = 3'd2;
   localparam logic [OP_W-1:0] OP_REMOVE_AT   = 3'd3;
   localparam logic [OP_W-1:0] OP_READ_AT     = 3'd4;
   localparam logic [OP_W-1:0] OP_READ_FIRST  = 3'd5;
   localparam logic [OP_W-1:0] OP_READ_LAST   = 3'd6;

   // Status codes
   localparam logic [ST_W-1:0] ST_OK    = 2'd0;
   localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
   localparam logic [ST_W-1:0] ST_RANGE = 2'd3;

   // Read address selects
   localparam logic [1:0] RD_SEL_PREV = 2'd0;
   localparam logic [1:0] RD_SEL_NEXT = 2'd1;
   localparam logic [1:0] RD_SEL_POS  = 2'd2;

   // Commands from controller to datapath
   typedef struct packed {
      logic       load;       // latch request word
      logic       st_latch;   // latch result status
      logic       idx_ins;    // index <= count
      logic       idx_rem;    // index <= removal position
      logic       idx_dec;
      logic       idx_inc;
      logic       rd_en;
      logic [1:0] rd_sel;
      logic       wr_en;
      logic       wr_elem;    // 1: element at insert position, 0: shifted word at index
      logic       cnt_inc;
      logic       cnt_dec;
      logic       rsp_load;
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic is_ins;
      logic is_rem;
      logic is_rd;
      logic op_ok;
      logic ins_more;
      logic rem_more;
      logic out_busy;
   } stat_type;

endpackage

@@ hdl/positional_list_engine_core.sv @@
// Top level of the positional list engine: bounded list used as stack/queue.
// Instantiates plist_ctrl and plist_dpath; uses plist_pkg.
//
//   channel | direction | handshake         | word
//   req     | in        | req_valid/stall   | operation, position, element
//   rsp     | out       | rsp_valid/stall   | status, read_value, entry_count
//
// One request at a time. A request is latched, decoded, run through its read
// or shift states and loaded into the result register in the done state; a
// refused request or the spare code goes from decode straight to done. Each
// entry moved by an insert or remove takes one memory read and one write.
// The next word is taken the cycle after the result is loaded. Reset clears
// the count, the control and the output valid; the entry store is not
// cleared. A result still stalled on rsp holds the next request in its final
// state until the output register frees.
module positional_list_engine_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [plist_pkg::OP_W-1:0]          req_operation,
   input  logic [plist_pkg::POS_W-1:0]         req_position,
   input  logic [plist_pkg::DATA_W-1:0]        req_element,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [plist_pkg::ST_W-1:0]          rsp_status,
   output logic [plist_pkg::DATA_W-1:0]        rsp_read_value,
   output logic [plist_pkg::CNT_PORT_W-1:0]    rsp_entry_count
);

   plist_pkg::cmd_type  cmd;
   plist_pkg::stat_type stat;

   plist_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   plist_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_operation   (req_operation),
      .req_position    (req_position),
      .req_element     (req_element),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_read_value  (rsp_read_value),
      .rsp_entry_count (rsp_entry_count)
   );

   // Full is reported only with the list at capacity
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == plist_pkg::ST_FULL)) |->
      (rsp_entry_count == plist_pkg::CNT_PORT_W'(plist_pkg::CAPACITY)))
      else $error("full status with list below capacity");

   // Empty is reported only with no entries
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == plist_pkg::ST_EMPTY)) |-> (rsp_entry_count == '0))
      else $error("empty status with entries present");

   // Failed requests return no data
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != plist_pkg::ST_OK)) |-> (rsp_read_value == '0))
      else $error("nonzero read value on error status");

   // A new result is only loaded into a free output slot
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> !(rsp_valid && rsp_stall))
      else $error("result loaded over a stalled result");

endmodule

@@ hdl/plist_dpath.sv @@
// Positional list datapath: request latch, entry memory, count, shift index
// and result register. Driven by plist_ctrl; uses plist_pkg.
module plist_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  plist_pkg::cmd_type                  cmd,
   output plist_pkg::stat_type                 stat,
   input  logic [plist_pkg::OP_W-1:0]          req_operation,
   input  logic [plist_pkg::POS_W-1:0]         req_position,
   input  logic [plist_pkg::DATA_W-1:0]        req_element,
   input  logic                                rsp_stall,
   output logic                                rsp_valid,
   output logic [plist_pkg::ST_W-1:0]          rsp_status,
   output logic [plist_pkg::DATA_W-1:0]        rsp_read_value,
   output logic [plist_pkg::CNT_PORT_W-1:0]    rsp_entry_count
);

   localparam int CW    = plist_pkg::CW;
   localparam int AW    = plist_pkg::AW;
   localparam int CMP_W = plist_pkg::CMP_W;

   // Latched request word
   logic [plist_pkg::OP_W-1:0]   op_ff;
   logic [plist_pkg::POS_W-1:0]  pos_ff;
   logic [plist_pkg::DATA_W-1:0] elem_ff;

   logic [CW-1:0]                count_ff, count_in;
   logic [CW-1:0]                idx_ff, idx_in;
   logic [plist_pkg::ST_W-1:0]   status_ff;
   logic [plist_pkg::DATA_W-1:0] rdata_ff;
   logic [plist_pkg::DATA_W-1:0] mem_ff [plist_pkg::CAPACITY];

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [plist_pkg::ST_W-1:0]   rsp_status_ff;
   logic [plist_pkg::DATA_W-1:0] rsp_value_ff;
   logic [CW-1:0]                rsp_count_ff;

   logic                         is_ins, is_rem, is_rd;
   logic [CMP_W-1:0]             pos_c, cnt_c;
   logic                         pos_past;  // position at or past count
   logic                         empty, full;
   logic [CW-1:0]                last_idx;
   logic [CW-1:0]                ins_pos;
   logic [CW-1:0]                rem_idx;
   logic [CW-1:0]                rd_pos;
   logic [plist_pkg::ST_W-1:0]   status_calc;
   logic [CW:0]                  idx_next_w;
   logic [CW-1:0]                idx_prev;
   logic [CW-1:0]                rd_idx;
   logic [CW-1:0]                wr_idx;
   logic [plist_pkg::DATA_W-1:0] wr_data;

   // Operation decode
   always_comb begin
      is_ins = op_ff inside {plist_pkg::OP_APPEND, plist_pkg::OP_INSERT_AT};
      is_rem = op_ff inside {plist_pkg::OP_REMOVE_LAST, plist_pkg::OP_REMOVE_AT};
      is_rd  = op_ff inside {plist_pkg::OP_READ_AT, plist_pkg::OP_READ_FIRST,
                             plist_pkg::OP_READ_LAST};
   end

   // Position arithmetic
   always_comb begin
      pos_c    = CMP_W'(pos_ff);
      cnt_c    = CMP_W'(count_ff);
      pos_past = (pos_c >= cnt_c);
      empty    = (count_ff == '0);
      full     = (count_ff == CW'(plist_pkg::CAPACITY));
      last_idx = count_ff - CW'(1);

      // append, or insert past the end, lands at count
      if ((op_ff == plist_pkg::OP_APPEND) || (pos_c > cnt_c)) begin
         ins_pos = count_ff;
      end else begin
         ins_pos = CW'(pos_ff);
      end

      if ((op_ff == plist_pkg::OP_REMOVE_AT) && !pos_past) begin
         rem_idx = CW'(pos_ff);
      end else begin
         rem_idx = last_idx;
      end

      case (op_ff)
         plist_pkg::OP_READ_FIRST: rd_pos = '0;
         plist_pkg::OP_READ_LAST:  rd_pos = last_idx;
         default:                  rd_pos = CW'(pos_ff);
      endcase
   end

   // Result status
   always_comb begin
      status_calc = plist_pkg::ST_OK;
      if (is_ins && full) begin
         status_calc = plist_pkg::ST_FULL;
      end else if ((is_rem || is_rd) && empty) begin
         status_calc = plist_pkg::ST_EMPTY;
      end else if ((op_ff == plist_pkg::OP_READ_AT) && pos_past) begin
         status_calc = plist_pkg::ST_RANGE;
      end
   end

   // Shift loop bounds
   always_comb begin
      idx_next_w = {1'b0, idx_ff} + (CW+1)'(1);
      idx_prev   = idx_ff - CW'(1);
   end

   always_comb begin
      stat.is_ins   = is_ins;
      stat.is_rem   = is_rem;
      stat.is_rd    = is_rd;
      stat.op_ok    = (status_calc == plist_pkg::ST_OK);
      stat.ins_more = (idx_ff > ins_pos);
      stat.rem_more = (idx_next_w < {1'b0, count_ff});
      stat.out_busy = rsp_valid_ff && rsp_stall;
   end

   // Memory addresses
   always_comb begin
      case (cmd.rd_sel)
         plist_pkg::RD_SEL_PREV: rd_idx = idx_prev;
         plist_pkg::RD_SEL_NEXT: rd_idx = idx_next_w[CW-1:0];
         default:                rd_idx = rd_pos;
      endcase
      wr_idx  = cmd.wr_elem ? ins_pos : idx_ff;
      wr_data = cmd.wr_elem ? elem_ff : rdata_ff;
   end

   // Entry memory, registered read
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem_ff[wr_idx[AW-1:0]] <= wr_data;
      end
      if (cmd.rd_en) begin
         rdata_ff <= mem_ff[rd_idx[AW-1:0]];
      end
   end

   // Request word and status latch
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_operation;
         pos_ff  <= req_position;
         elem_ff <= req_element;
      end
      if (cmd.st_latch) begin
         status_ff <= status_calc;
      end
   end

   // Count and shift index
   always_comb begin
      count_in = count_ff;
      if (cmd.cnt_inc) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - CW'(1);
      end

      idx_in = idx_ff;
      if (cmd.idx_ins) begin
         idx_in = count_ff;
      end else if (cmd.idx_rem) begin
         idx_in = rem_idx;
      end else if (cmd.idx_dec) begin
         idx_in = idx_prev;
      end else if (cmd.idx_inc) begin
         idx_in = idx_next_w[CW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      idx_ff <= idx_in;
   end

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_count_ff  <= count_ff;
         if (is_rd && (status_ff == plist_pkg::ST_OK)) begin
            rsp_value_ff <= rdata_ff;
         end else begin
            rsp_value_ff <= '0;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_read_value  = rsp_value_ff;
   assign rsp_entry_count = plist_pkg::CNT_PORT_W'(rsp_count_ff);

endmodule

@@ hdl/plist_ctrl.sv @@
// Positional list controller: sequences decode, entry shifting, reads and
// result hand-off. Commands plist_dpath; uses plist_pkg.
module plist_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  plist_pkg::stat_type stat,
   output plist_pkg::cmd_type  cmd
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_DECODE   = 3'd1;
   localparam logic [2:0] S_INS_LOOP = 3'd2;
   localparam logic [2:0] S_INS_WR   = 3'd3;
   localparam logic [2:0] S_REM_LOOP = 3'd4;
   localparam logic [2:0] S_REM_WR   = 3'd5;
   localparam logic [2:0] S_RD       = 3'd6;
   localparam logic [2:0] S_DONE     = 3'd7;

   logic [2:0] state_ff, state_in;

   assign req_stall = (state_ff != S_IDLE);

   // Next state and command decode
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.rd_sel = plist_pkg::RD_SEL_POS;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.st_latch = 1'b1;
            if (!stat.op_ok) begin
               state_in = S_DONE;
            end else if (stat.is_ins) begin
               cmd.idx_ins = 1'b1;
               state_in    = S_INS_LOOP;
            end else if (stat.is_rem) begin
               cmd.idx_rem = 1'b1;
               state_in    = S_REM_LOOP;
            end else if (stat.is_rd) begin
               state_in = S_RD;
            end else begin
               state_in = S_DONE;
            end
         end
         // move entries up one slot, from the top down to the insert position
         S_INS_LOOP: begin
            if (stat.ins_more) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = plist_pkg::RD_SEL_PREV;
               state_in   = S_INS_WR;
            end else begin
               cmd.wr_en   = 1'b1;
               cmd.wr_elem = 1'b1;
               cmd.cnt_inc = 1'b1;
               state_in    = S_DONE;
            end
         end
         S_INS_WR: begin
            cmd.wr_en   = 1'b1;
            cmd.idx_dec = 1'b1;
            state_in    = S_INS_LOOP;
         end
         // move entries down one slot, from the removal position upward
         S_REM_LOOP: begin
            if (stat.rem_more) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = plist_pkg::RD_SEL_NEXT;
               state_in   = S_REM_WR;
            end else begin
               cmd.cnt_dec = 1'b1;
               state_in    = S_DONE;
            end
         end
         S_REM_WR: begin
            cmd.wr_en   = 1'b1;
            cmd.idx_inc = 1'b1;
            state_in    = S_REM_LOOP;
         end
         S_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = S_DONE;
         end
         S_DONE: begin
            if (!stat.out_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
